>>> rtl/core/pafs_pkg.sv
`timescale 1ns / 1ps

package pafs_pkg;

  // Default fixed-point format and derived unit width (2 * force width + 2)
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int INTEG_BITS    = 48;
  localparam int UNIT_W_DEF    = 102;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 3'd7;

  // Reported phase codes
  localparam logic [1:0] PH_HOLD     = 2'd0;
  localparam logic [1:0] PH_APPROACH = 2'd1;
  localparam logic [1:0] PH_ARRIVED  = 2'd2;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV,
    UOP_SQRT
  } pafs_uop_t;

  typedef struct packed {
    logic      start;
    pafs_uop_t op;
  } pafs_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pafs_stat_t;

  // Input transaction payload
  typedef struct packed {
    logic               action;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } pafs_in_t;

  // Output transaction payload
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [1:0]         phase;
  } pafs_out_t;

endpackage

>>> rtl/core/pid_approach_flight_step.sv
`timescale 1ns / 1ps
// Load, hold and arrived transactions pass from ST_IDLE through ST_DONE to the output register.
// An approach step runs up to 33 multiplies (the divides by 100, 5 and 20000 are
// reciprocal multiplies), up to 9 divides and up to 2 square roots on one shared unit.
// The default data format is Q16.16. One transaction at a time.
// Reset (synchronous, active high) clears all motion state and loads default config.
module pid_approach_flight_step #(
  parameter int FRAC_BITS = pafs_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = pafs_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pafs_pkg::pafs_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pafs_pkg::pafs_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [pafs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import pafs_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int W  = WORD_BITS;
  localparam int IB = INTEG_BITS;
  localparam int FW = ((W + 9 > IB - 1) ? W + 9 : IB - 1) + 3;
  localparam int UW = 2 * FW + 2;
  localparam int MB = (F + 1 > 23) ? F + 1 : 23;
  localparam logic [1:0] AX_LAST = 2'd2;

  localparam logic signed [UW-1:0] WMAX = $signed({{(UW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [UW-1:0] WMIN = ~WMAX;
  localparam logic signed [UW-1:0] IMAX = $signed({{(UW-IB+1){1'b0}}, {(IB-1){1'b1}}});
  localparam logic signed [UW-1:0] IMIN = ~IMAX;

  // reciprocals for the constant divides: exact floor for numerators below 2^W (2^IB for 5)
  localparam int SH100 = W + 7;
  localparam int SH20K = W + 15;
  localparam int SH5   = IB + 3;
  localparam logic [UW-1:0] RCP100 = ((UW'(1) << SH100) + UW'(99)) / UW'(100);
  localparam logic [UW-1:0] RCP20K = ((UW'(1) << SH20K) + UW'(19999)) / UW'(20000);
  localparam logic [UW-1:0] RCP5   = ((UW'(1) << SH5) + UW'(4)) / UW'(5);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ESQ, ST_RAD, ST_IDIV, ST_PDIV, ST_LSQ, ST_LLIM, ST_LSQRT,
    ST_LMUL, ST_LDIV, ST_LEND, ST_ADIV, ST_VDIV, ST_VCOPY, ST_PVDIV, ST_PADIV,
    ST_DONE
  } state_t;

  state_t st;

  // configuration
  logic signed [31:0] tgt [3];
  logic [30:0]        radius;
  logic [15:0]        hold;
  logic [30:0]        flim;
  logic [30:0]        slim;
  logic [MB-1:0]      mass;

  // motion and controller state
  logic signed [W-1:0]  pos [3];
  logic signed [W-1:0]  vel [3];
  logic signed [W-1:0]  acc [3];
  logic signed [IB-1:0] integ [3];
  logic signed [W-1:0]  prev [3];
  logic [15:0]          tick;
  logic                 arrived;

  // working registers
  logic signed [W-1:0]  e [3];
  logic signed [FW-1:0] f [3];
  logic [UW-1:0]        sum;
  logic [UW-1:0]        prod;
  logic [FW-1:0]        mroot;
  logic [1:0]           ax;
  logic                 lsel;
  logic                 pend;
  logic [1:0]           ph;

  // shared unit
  pafs_req_t     ureq;
  pafs_stat_t    ust;
  logic [UW-1:0] ua;
  logic [UW-1:0] ub;
  logic [UW-1:0] ures;
  logic          ustart;

  logic [15:0]          tick_nx;
  logic [MB-1:0]        mass_eff;
  logic [UW-1:0]        mass10;
  logic [30:0]          lim;
  logic [UW-1:0]        cq;
  logic signed [UW-1:0] ediff;
  logic signed [UW-1:0] fnew;
  logic [1:0]           cur_ph;

  function automatic logic signed [W-1:0] sat_w(input logic signed [UW-1:0] v);
    if (v > WMAX) return WMAX[W-1:0];
    if (v < WMIN) return WMIN[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [IB-1:0] sat_i(input logic signed [UW-1:0] v);
    if (v > IMAX) return IMAX[IB-1:0];
    if (v < IMIN) return IMIN[IB-1:0];
    return v[IB-1:0];
  endfunction

  function automatic logic [UW-1:0] mag(input logic signed [UW-1:0] v);
    return v[UW-1] ? -v : v;
  endfunction

  function automatic logic signed [UW-1:0] apply(input logic neg, input logic [UW-1:0] q);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  pafs_unit #(.UW(UW)) u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (ureq),
    .a      (ua),
    .b      (ub),
    .stat   (ust),
    .result (ures)
  );

  assign in_ready = (st == ST_IDLE);
  assign ustart   = !pend && (st inside {ST_ESQ, ST_RAD, ST_IDIV, ST_PDIV, ST_LSQ, ST_LLIM,
                                         ST_LSQRT, ST_LMUL, ST_LDIV, ST_ADIV, ST_VDIV,
                                         ST_PVDIV, ST_PADIV});

  // helpers: tick, mass, limit, phase, constant-divide quotient, force term
  always_comb begin
    tick_nx  = (tick == 16'hFFFF) ? tick : tick + 16'd1;
    mass_eff = (mass == '0) ? MB'(1) : mass;
    mass10   = (UW'(mass_eff) << 3) + (UW'(mass_eff) << 1);
    lim      = lsel ? slim : flim;
    cur_ph   = (tick < hold) ? PH_HOLD : (arrived ? PH_ARRIVED : PH_APPROACH);
    case (st)
      ST_PDIV:  cq = ures >> SH5;
      ST_PADIV: cq = ures >> SH20K;
      default:  cq = ures >> SH100;
    endcase
    ediff    = UW'(e[ax]) - UW'(prev[ax]);
    fnew     = (UW'(e[ax]) <<< 2) + apply(integ[ax][IB-1], cq)
             + (ediff <<< 7) + (ediff <<< 6) + (ediff <<< 3)
             + ((ax == AX_LAST) ? mass10 : '0);
  end

  // operand select for the shared unit
  always_comb begin
    ua      = '0;
    ub      = '0;
    ureq.op = UOP_DIV;
    case (st)
      ST_ESQ: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(e[ax]));
        ub = ua;
      end
      ST_RAD: begin
        ureq.op = UOP_MUL;
        ua = UW'(radius);
        ub = ua;
      end
      ST_IDIV: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(e[ax])) + UW'(50);
        ub = RCP100;
      end
      ST_PDIV: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(integ[ax])) + UW'(2);
        ub = RCP5;
      end
      ST_LSQ: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(f[ax]));
        ub = ua;
      end
      ST_LLIM: begin
        ureq.op = UOP_MUL;
        ua = UW'(lim);
        ub = ua;
      end
      ST_LSQRT: begin
        ureq.op = UOP_SQRT;
        ua = sum;
      end
      ST_LMUL: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(f[ax]));
        ub = UW'(lim);
      end
      ST_LDIV: begin
        ua = prod;
        ub = UW'(mroot);
      end
      ST_ADIV: begin
        ua = (mag(UW'(f[ax])) << F) + UW'(mass_eff >> 1);
        ub = UW'(mass_eff);
      end
      ST_VDIV: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(acc[ax])) + UW'(50);
        ub = RCP100;
      end
      ST_PVDIV: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(vel[ax])) + UW'(50);
        ub = RCP100;
      end
      ST_PADIV: begin
        ureq.op = UOP_MUL;
        ua = mag(UW'(acc[ax])) + UW'(10000);
        ub = RCP20K;
      end
      default: begin
        ua = '0;
      end
    endcase
    ureq.start = ustart;
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      tick      <= '0;
      arrived   <= 1'b0;
      tgt[0]    <= '0;
      tgt[1]    <= '0;
      tgt[2]    <= 32'(50 * (1 << F));
      radius    <= 31'(10 * (1 << F));
      hold      <= 16'd500;
      flim      <= 31'(20 * (1 << F));
      slim      <= 31'(2 * (1 << F));
      mass      <= MB'(1 << F);
      for (int i = 0; i < 3; i++) begin
        pos[i]   <= '0;
        vel[i]   <= '0;
        acc[i]   <= '0;
        integ[i] <= '0;
        prev[i]  <= '0;
      end
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_X:  tgt[0] <= $signed(cfg_data);
          CFG_TARGET_Y:  tgt[1] <= $signed(cfg_data);
          CFG_TARGET_Z:  tgt[2] <= $signed(cfg_data);
          CFG_RADIUS:    radius <= cfg_data[30:0];
          CFG_HOLD:      hold   <= cfg_data[15:0];
          CFG_FORCE_LIM: flim   <= cfg_data[30:0];
          CFG_SPEED_LIM: slim   <= cfg_data[30:0];
          CFG_MASS:      mass   <= MB'(cfg_data[22:0]);
          default: begin
            hold <= hold;
          end
        endcase
      end

      if (ustart) pend <= 1'b1;
      else if (ust.done) pend <= 1'b0;

      if (out_valid && out_ready && st != ST_DONE) out_valid <= 1'b0;

      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.action) begin
              pos[0] <= sat_w(UW'(in_data.load_x));
              pos[1] <= sat_w(UW'(in_data.load_y));
              pos[2] <= sat_w(UW'(in_data.load_z));
              ph     <= cur_ph;
              st     <= ST_DONE;
            end else begin
              tick <= tick_nx;
              if (tick_nx < hold) begin
                for (int i = 0; i < 3; i++) begin
                  vel[i] <= '0;
                  acc[i] <= '0;
                end
                ph <= PH_HOLD;
                st <= ST_DONE;
              end else if (arrived) begin
                ph <= PH_ARRIVED;
                st <= ST_DONE;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  e[i] <= sat_w(UW'(tgt[i]) - UW'(pos[i]));
                end
                sum <= '0;
                ax  <= '0;
                st  <= ST_ESQ;
              end
            end
          end
        end
        // distance check
        ST_ESQ: begin
          if (ust.done) begin
            sum <= sum + ures;
            if (ax == AX_LAST) begin
              ax <= '0;
              st <= ST_RAD;
            end else begin
              ax <= ax + 2'd1;
            end
          end
        end
        ST_RAD: begin
          if (ust.done) begin
            if (sum > ures) begin
              st <= ST_IDIV;
            end else begin
              arrived <= 1'b1;
              ph      <= PH_ARRIVED;
              st      <= ST_DONE;
            end
          end
        end
        // PID terms per axis
        ST_IDIV: begin
          if (ust.done) begin
            integ[ax] <= sat_i(UW'(integ[ax]) + apply(e[ax][W-1], cq));
            st        <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (ust.done) begin
            f[ax]    <= FW'(fnew);
            prev[ax] <= e[ax];
            if (ax == AX_LAST) begin
              ax   <= '0;
              sum  <= '0;
              lsel <= 1'b0;
              st   <= ST_LSQ;
            end else begin
              ax <= ax + 2'd1;
              st <= ST_IDIV;
            end
          end
        end
        // vector magnitude clamp, shared by force and speed
        ST_LSQ: begin
          if (ust.done) begin
            sum <= sum + ures;
            if (ax == AX_LAST) begin
              ax <= '0;
              st <= ST_LLIM;
            end else begin
              ax <= ax + 2'd1;
            end
          end
        end
        ST_LLIM: begin
          if (ust.done) begin
            st <= (sum > ures) ? ST_LSQRT : ST_LEND;
          end
        end
        ST_LSQRT: begin
          if (ust.done) begin
            mroot <= ures[FW-1:0];
            ax    <= '0;
            st    <= ST_LMUL;
          end
        end
        ST_LMUL: begin
          if (ust.done) begin
            prod <= ures;
            st   <= ST_LDIV;
          end
        end
        ST_LDIV: begin
          if (ust.done) begin
            f[ax] <= FW'(apply(f[ax][FW-1], ures));
            if (ax == AX_LAST) begin
              ax <= '0;
              st <= ST_LEND;
            end else begin
              ax <= ax + 2'd1;
              st <= ST_LMUL;
            end
          end
        end
        ST_LEND: begin
          ax <= '0;
          if (lsel) begin
            for (int i = 0; i < 3; i++) begin
              vel[i] <= W'(f[i]);
            end
            st <= ST_PVDIV;
          end else begin
            st <= ST_ADIV;
          end
        end
        // acceleration and velocity per axis
        ST_ADIV: begin
          if (ust.done) begin
            acc[ax] <= sat_w(apply(f[ax][FW-1], ures));
            st      <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          if (ust.done) begin
            vel[ax] <= sat_w(UW'(vel[ax]) + apply(acc[ax][W-1], cq));
            if (ax == AX_LAST) begin
              st <= ST_VCOPY;
            end else begin
              ax <= ax + 2'd1;
              st <= ST_ADIV;
            end
          end
        end
        ST_VCOPY: begin
          for (int i = 0; i < 3; i++) begin
            f[i] <= FW'(vel[i]);
          end
          sum  <= '0;
          lsel <= 1'b1;
          ax   <= '0;
          st   <= ST_LSQ;
        end
        // position update per axis
        ST_PVDIV: begin
          if (ust.done) begin
            prod <= apply(vel[ax][W-1], cq);
            st   <= ST_PADIV;
          end
        end
        ST_PADIV: begin
          if (ust.done) begin
            pos[ax] <= sat_w(UW'(pos[ax]) + $signed(prod) + apply(acc[ax][W-1], cq));
            if (ax == AX_LAST) begin
              ph <= PH_APPROACH;
              st <= ST_DONE;
            end else begin
              ax <= ax + 2'd1;
              st <= ST_PVDIV;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_data.pos_x <= 32'(pos[0]);
            out_data.pos_y <= 32'(pos[1]);
            out_data.pos_z <= 32'(pos[2]);
            out_data.vel_x <= 32'(vel[0]);
            out_data.vel_y <= 32'(vel[1]);
            out_data.vel_z <= 32'(vel[2]);
            out_data.acc_x <= 32'(acc[0]);
            out_data.acc_y <= 32'(acc[1]);
            out_data.acc_z <= 32'(acc[2]);
            out_data.phase <= ph;
            st             <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // unit is only started when idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst) ustart |-> !ust.busy)
    else $error("unit started while busy");

  // a unit result is always awaited by the sequencer
  a_done_pend: assert property (@(posedge clk) disable iff (rst) ust.done |-> pend)
    else $error("unit result with no pending operation");

  // no new transaction while an operation is outstanding
  a_ready_free: assert property (@(posedge clk) disable iff (rst) in_ready |-> !pend)
    else $error("input ready with unit operation pending");

endmodule

>>> rtl/core/pafs_unit.sv
`timescale 1ns / 1ps

module pafs_unit #(
  parameter int UW = pafs_pkg::UNIT_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pafs_pkg::pafs_req_t   req,
  input  logic [UW-1:0]         a,
  input  logic [UW-1:0]         b,
  output pafs_pkg::pafs_stat_t  stat,
  output logic [UW-1:0]         result
);
  import pafs_pkg::*;

  localparam int HW = UW / 2;
  localparam int RW = HW + 2;
  localparam int CW = $clog2(UW);

  logic          run;
  logic          done;
  pafs_uop_t     op_r;
  logic [CW-1:0] cnt;
  logic [UW-1:0] acc;
  logic [UW-1:0] x;
  logic [UW-1:0] y;
  logic [RW-1:0] rem;

  logic [RW-1:0] rem_d;
  logic          div_ge;
  logic [RW-1:0] rem_s;
  logic [RW-1:0] trial;
  logic          sq_ge;

  // restoring divide step and digit-by-digit root step
  always_comb begin
    rem_d  = {rem[RW-2:0], x[UW-1]};
    div_ge = rem_d >= y[RW-1:0];
    rem_s  = {rem[RW-3:0], x[UW-1:UW-2]};
    trial  = {acc[RW-3:0], 2'b01};
    sq_ge  = rem_s >= trial;
  end

  // one step per cycle: mul HW steps, div UW steps, sqrt HW steps
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!run && req.start) begin
        run  <= 1'b1;
        op_r <= req.op;
        x    <= a;
        y    <= b;
        acc  <= '0;
        rem  <= '0;
        cnt  <= (req.op == UOP_DIV) ? CW'(UW - 1) : CW'(HW - 1);
      end else if (run) begin
        case (op_r)
          UOP_MUL: begin
            if (x[0]) acc <= acc + y;
            x <= x >> 1;
            y <= y << 1;
          end
          UOP_DIV: begin
            rem <= div_ge ? rem_d - y[RW-1:0] : rem_d;
            acc <= {acc[UW-2:0], div_ge};
            x   <= x << 1;
          end
          UOP_SQRT: begin
            rem <= sq_ge ? rem_s - trial : rem_s;
            acc <= {acc[UW-2:0], sq_ge};
            x   <= x << 2;
          end
          default: begin
            acc <= acc;
          end
        endcase
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign result    = acc;
  assign stat.busy = run;
  assign stat.done = done;

endmodule

>>> tb/sv/tb_pid_approach_flight_step.sv
`timescale 1ns / 1ps

module tb_pid_approach_flight_step;
  import pafs_pkg::*;

  typedef longint trip_t [3];

  localparam longint ONE_Q     = 64'sd65536;
  localparam longint CYCLE_CAP = 64'd30000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pafs_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pafs_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pafs_in_t  step_q[$];
  pafs_out_t state_q[$];
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  longint    cycle_cnt = 0;

  // Mirror of the vehicle and its settings
  longint          m_pos[3], m_vel[3], m_acc[3], m_integ[3], m_prev[3];
  int              m_ticks;
  bit              m_arrived;
  longint          m_tgt[3];
  longint unsigned m_radius, m_hold, m_flim, m_slim, m_mass;

  pid_approach_flight_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint sat_n(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint unsigned mag(longint v);
    longint unsigned r;
    r = v;
    if (v < 0) r = -r;
    return r;
  endfunction

  // Round to nearest, ties away from zero; d > 0
  function automatic longint rnd_div(longint n, longint d);
    longint unsigned du;
    longint unsigned q;
    du = d;
    q = (mag(n) + du / 2) / du;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [127:0] sq_sum(trip_t v);
    logic [127:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) s += {64'b0, mag(v[i])} * {64'b0, mag(v[i])};
    return s;
  endfunction

  // Scale a vector down to magnitude lim when it is longer
  function automatic trip_t clamp_vec(trip_t v, longint unsigned lim);
    logic [127:0] s;
    logic [127:0] cc;
    logic [127:0] q;
    logic [63:0]  root;
    logic [63:0]  c;
    trip_t        r;
    r = v;
    s = sq_sum(v);
    if (s <= {64'b0, lim} * {64'b0, lim}) return r;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (64'd1 << b);
      cc = {64'b0, c} * {64'b0, c};
      if (cc <= s) root = c;
    end
    for (int i = 0; i < 3; i++) begin
      q = ({64'b0, mag(v[i])} * {64'b0, lim}) / {64'b0, root};
      r[i] = (v[i] < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    end
    return r;
  endfunction

  function automatic logic [1:0] live_phase();
    if (longint'(m_ticks) < longint'(m_hold)) return PH_HOLD;
    return m_arrived ? PH_ARRIVED : PH_APPROACH;
  endfunction

  // Advance the mirror by one transaction and return the expected state
  function automatic pafs_out_t advance_vehicle(pafs_in_t t);
    pafs_out_t o;
    logic [1:0] ph;
    trip_t   e, f, a;
    longint  ms;
    if (t.action) begin
      m_pos[0] = sat_n(longint'(t.load_x), 32);
      m_pos[1] = sat_n(longint'(t.load_y), 32);
      m_pos[2] = sat_n(longint'(t.load_z), 32);
      ph = live_phase();
    end else begin
      if (m_ticks < 65535) m_ticks++;
      if (longint'(m_ticks) < longint'(m_hold)) begin
        for (int i = 0; i < 3; i++) begin
          m_vel[i] = 0;
          m_acc[i] = 0;
        end
        ph = PH_HOLD;
      end else if (m_arrived) begin
        ph = PH_ARRIVED;
      end else begin
        ms = (m_mass == 0) ? 1 : longint'(m_mass);
        for (int i = 0; i < 3; i++) e[i] = sat_n(m_tgt[i] - m_pos[i], 32);
        if (sq_sum(e) <= {64'b0, m_radius} * {64'b0, m_radius}) begin
          m_arrived = 1'b1;
          ph = PH_ARRIVED;
        end else begin
          // PID force with gravity on z
          for (int i = 0; i < 3; i++) begin
            m_integ[i] = sat_n(m_integ[i] + rnd_div(e[i], 100), INTEG_BITS);
            f[i] = 4 * e[i] + rnd_div(m_integ[i], 5) + 200 * (e[i] - m_prev[i]);
            m_prev[i] = e[i];
          end
          f[2] += 10 * ms;
          f = clamp_vec(f, m_flim);
          for (int i = 0; i < 3; i++) begin
            a[i] = sat_n(rnd_div(f[i] * ONE_Q, ms), 32);
            m_vel[i] = sat_n(m_vel[i] + rnd_div(a[i], 100), 32);
          end
          m_vel = clamp_vec(m_vel, m_slim);
          for (int i = 0; i < 3; i++) begin
            m_pos[i] = sat_n(m_pos[i] + rnd_div(m_vel[i], 100) + rnd_div(a[i], 20000), 32);
            m_acc[i] = a[i];
          end
          ph = PH_APPROACH;
        end
      end
    end
    o.pos_x = m_pos[0][31:0];
    o.pos_y = m_pos[1][31:0];
    o.pos_z = m_pos[2][31:0];
    o.vel_x = m_vel[0][31:0];
    o.vel_y = m_vel[1][31:0];
    o.vel_z = m_vel[2][31:0];
    o.acc_x = m_acc[0][31:0];
    o.acc_y = m_acc[1][31:0];
    o.acc_z = m_acc[2][31:0];
    o.phase = ph;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] act);
    if (expv !== act) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expv, act);
      err_cnt++;
    end
  endfunction

  // Driver: feeds pending transactions, idles at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) state_q.push_back(advance_vehicle(in_data));
      if (!in_valid || in_ready) begin
        if (step_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= step_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls and result checks
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (state_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        pafs_out_t x;
        x = state_q.pop_front();
        check_field("pos_x", x.pos_x, out_data.pos_x);
        check_field("pos_y", x.pos_y, out_data.pos_y);
        check_field("pos_z", x.pos_z, out_data.pos_z);
        check_field("vel_x", x.vel_x, out_data.vel_x);
        check_field("vel_y", x.vel_y, out_data.vel_y);
        check_field("vel_z", x.vel_z, out_data.vel_z);
        check_field("acc_x", x.acc_x, out_data.acc_x);
        check_field("acc_y", x.acc_y, out_data.acc_y);
        check_field("acc_z", x.acc_z, out_data.acc_z);
        check_field("phase", 32'(x.phase), 32'(out_data.phase));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    while (step_q.size() > 0 || in_valid || state_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET_X:  m_tgt[0] = longint'(signed'(v));
      CFG_TARGET_Y:  m_tgt[1] = longint'(signed'(v));
      CFG_TARGET_Z:  m_tgt[2] = longint'(signed'(v));
      CFG_RADIUS:    m_radius = v[30:0];
      CFG_HOLD:      m_hold   = v[15:0];
      CFG_FORCE_LIM: m_flim   = v[30:0];
      CFG_SPEED_LIM: m_slim   = v[30:0];
      default:       m_mass   = v[22:0];
    endcase
  endtask

  function automatic void add_move(bit ld, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pafs_in_t t;
    t.action = ld;
    t.load_x = x;
    t.load_y = y;
    t.load_z = z;
    step_q.push_back(t);
  endfunction

  // Coordinate: mostly within 100 m, sometimes full range or extreme
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      default: return 32'(int'($urandom_range(13107200)) - 6553600);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'h7fffffff;
      2:       return $urandom;
      default: return $urandom_range(3276800, 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'd1;
      2:       return 32'd6553600;
      3:       return 32'h007fffff;
      default: return $urandom_range(655360, 16384);
    endcase
  endfunction

  task automatic set_modes(int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  task automatic random_moves(int n, int load_pct);
    for (int i = 0; i < n; i++)
      add_move($urandom_range(99) < load_pct, pick_coord(), pick_coord(), pick_coord());
  endtask

  // Stimulus sequence
  initial begin
    m_tgt[0] = 0;
    m_tgt[1] = 0;
    m_tgt[2] = 50 * ONE_Q;
    m_radius = 10 * ONE_Q;
    m_hold   = 500;
    m_flim   = 20 * ONE_Q;
    m_slim   = 2 * ONE_Q;
    m_mass   = ONE_Q;
    for (int i = 0; i < 3; i++) begin
      m_pos[i] = 0; m_vel[i] = 0; m_acc[i] = 0; m_integ[i] = 0; m_prev[i] = 0;
    end
    m_ticks   = 0;
    m_arrived = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Holding on the ground with default settings, extreme loads
    set_modes(0);
    add_move(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_move(1'b0, 32'h80000000, 32'h7fffffff, 32'h0);
    add_move(1'b1, 32'h80000000, 32'h7fffffff, 32'h0);
    add_move(1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_move(1'b1, 32'h0, 32'h0, 32'h0);
    add_move(1'b0, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // Approach from the ground: first derivative kick; then from far away
    write_reg(CFG_HOLD, 32'd0);
    write_reg(CFG_RADIUS, 32'd0);
    for (int i = 0; i < 4; i++) add_move(1'b0, 32'h0, 32'h0, 32'h0);
    add_move(1'b1, 32'h7fffffff, 32'h80000000, 32'h80000000);
    for (int i = 0; i < 3; i++) add_move(1'b0, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // Smallest mass, widest limits, extreme target
    write_reg(CFG_MASS, 32'd0);
    write_reg(CFG_FORCE_LIM, 32'h7fffffff);
    write_reg(CFG_SPEED_LIM, 32'h7fffffff);
    write_reg(CFG_TARGET_X, 32'h80000000);
    write_reg(CFG_TARGET_Y, 32'h7fffffff);
    write_reg(CFG_TARGET_Z, 32'h80000000);
    for (int i = 0; i < 4; i++) add_move(1'b0, 32'h0, 32'h0, 32'h0);
    add_move(1'b1, 32'h0, 32'h0, 32'h0);
    add_move(1'b0, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // Zero limits and a heavy mass of 100.0
    write_reg(CFG_FORCE_LIM, 32'h0);
    write_reg(CFG_SPEED_LIM, 32'h0);
    write_reg(CFG_MASS, 32'd6553600);
    add_move(1'b0, 32'h0, 32'h0, 32'h0);
    add_move(1'b0, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // Random phases; radius stays zero so the vehicle arrives only on reaching the target exactly
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_TARGET_X, pick_coord());
      write_reg(CFG_TARGET_Y, pick_coord());
      write_reg(CFG_TARGET_Z, pick_coord());
      write_reg(CFG_HOLD, (p == 3) ? 32'd65535 : ((p == 5) ? 32'd400 : $urandom_range(6)));
      write_reg(CFG_FORCE_LIM, pick_limit());
      write_reg(CFG_SPEED_LIM, pick_limit());
      write_reg(CFG_MASS, pick_mass());
      set_modes(p);
      random_moves(170, 30);
      wait_idle();
    end

    // Arrival: widest radius, then arrived steps and loads
    write_reg(CFG_HOLD, 32'd0);
    write_reg(CFG_RADIUS, 32'h7fffffff);
    set_modes(3);
    random_moves(40, 40);
    wait_idle();

    // Holding again after arrival clears velocity and reports holding
    write_reg(CFG_HOLD, 32'd65535);
    write_reg(CFG_RADIUS, 32'd655360);
    set_modes(2);
    random_moves(20, 40);
    wait_idle();

    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
